// ===== design/bwcd_pkg.sv =====
// ----------------------------------------------------------------------------
// bwcd_pkg
// Shared types, register map and reset values for the boundary wire code
// detector.
// ----------------------------------------------------------------------------
package bwcd_pkg;

  localparam int CODE_MAX_DEF      = 4;
  localparam int PULSE_UNIT_US_DEF = 100;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam int AGE_W  = 22;
  localparam int HELD_W = 16;
  localparam int LEN_REG_W = 3;

  localparam logic [AGE_W-1:0]     VALID_MS_RST  = AGE_W'(120000);
  localparam logic [HELD_W-1:0]    FILTER_MS_RST = HELD_W'(300);
  localparam logic [LEN_REG_W-1:0] CODE_LEN_RST  = LEN_REG_W'(1);

  typedef enum logic [2:0] {
    REG_INSIDE_WORDS  = 3'd0,
    REG_INSIDE_LEN    = 3'd1,
    REG_OUTSIDE_WORDS = 3'd2,
    REG_OUTSIDE_LEN   = 3'd3,
    REG_VALID_MS      = 3'd4,
    REG_MISSING_OUT   = 3'd5,
    REG_FILTER_MS     = 3'd6
  } reg_idx_t;

  typedef enum logic {
    ACT_EDGE = 1'b0,
    ACT_TICK = 1'b1
  } action_t;

  typedef struct packed {
    logic        action;
    logic [31:0] time_us;
  } bwcd_in_t;

  typedef struct packed {
    logic       filtered_in;
    logic       raw_out;
    logic       signal_missing;
    logic       out_of_bounds;
    logic       bounds_changed;
    logic [7:0] pulse_units;
  } bwcd_out_t;

  // Code element idx of a packed code word; only four bytes exist.
  function automatic logic [7:0] code_elem(input logic [31:0] words,
                                           input logic [2:0]  idx);
    logic [7:0] elem;
    elem = 8'd0;
    if (idx < 3'd4) begin
      elem = words[8*idx[1:0] +: 8];
    end
    return elem;
  endfunction

  // Within plus or minus one unit.
  function automatic logic near_match(input logic [7:0] units,
                                      input logic [7:0] want);
    return (units == want) ||
           ({1'b0, units} == ({1'b0, want} + 9'd1)) ||
           ({1'b0, want} == ({1'b0, units} + 9'd1));
  endfunction

endpackage

// ===== design/boundary_wire_code_detector.sv =====
// ----------------------------------------------------------------------------
// boundary_wire_code_detector
// Decodes perimeter wire pulse codes into inside/outside status and tracks
// signal age and inside hold time.
// ----------------------------------------------------------------------------
//
//  channel   signals                                   carries
//  -------   ---------------------------------------   ---------------------
//  item      item_valid / item_ready / item            edge or ms tick request
//  result    result_valid / result_ready / result      status, one per request
//  config    psel penable pwrite paddr pwdata prdata   code and timing regs
//
//  One request per cycle sustained while result_ready holds: a request lands in the
//  input register, then one pass of logic (interval, divide by unit, match, timers)
//  writes the result register and the detector state in the same edge.
//  A stalled result holds the result register; the input register still
//  takes one more request, then item_ready drops.
//  Synchronous reset clears control and state; no clearing pass is needed.
//
module boundary_wire_code_detector
  import bwcd_pkg::*;
#(
  parameter int CODE_MAX      = CODE_MAX_DEF,
  parameter int PULSE_UNIT_US = PULSE_UNIT_US_DEF
) (
  input  logic              clk,
  input  logic              rst,

  input  logic              item_valid,
  output logic              item_ready,
  input  bwcd_in_t          item,

  output logic              result_valid,
  input  logic              result_ready,
  output bwcd_out_t         result,

  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  // Widths that follow from the parameters.
  localparam int LEN_W  = $clog2(CODE_MAX + 1);
  localparam int PROG_W = (CODE_MAX > 1) ? $clog2(CODE_MAX) : 1;

  // Saturation: (delta + half) >= 256 units gives 255.
  localparam longint SAT_LIMIT = 256 * PULSE_UNIT_US;
  localparam int     SAT_W     = $clog2(SAT_LIMIT);
  localparam int     HALF_UNIT = PULSE_UNIT_US / 2;
  // Reciprocal multiply: exact quotient for every value below 2^SAT_W.
  localparam int     RSHIFT    = SAT_W + $clog2(PULSE_UNIT_US);
  localparam longint RECIP     = ((64'd1 << RSHIFT) + PULSE_UNIT_US - 1) / PULSE_UNIT_US;
  localparam int     RECIP_W   = SAT_W + 2;
  localparam int     PROD_W    = SAT_W + RECIP_W;

  localparam logic [LEN_W-1:0]  CODE_MAX_L = LEN_W'(CODE_MAX);
  localparam logic [AGE_W-1:0]  AGE_MAX    = {AGE_W{1'b1}};
  localparam logic [HELD_W-1:0] HELD_MAX   = {HELD_W{1'b1}};

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [31:0]          inside_code_words;
  logic [LEN_REG_W-1:0] inside_code_length;
  logic [31:0]          outside_code_words;
  logic [LEN_REG_W-1:0] outside_code_length;
  logic [AGE_W-1:0]     signal_valid_ms;
  logic                 missing_is_out;
  logic [HELD_W-1:0]    in_filter_ms;

  logic     cfg_write;
  reg_idx_t cfg_idx;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_idx   = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      inside_code_words   <= '0;
      inside_code_length  <= CODE_LEN_RST;
      outside_code_words  <= '0;
      outside_code_length <= CODE_LEN_RST;
      signal_valid_ms     <= VALID_MS_RST;
      missing_is_out      <= 1'b0;
      in_filter_ms        <= FILTER_MS_RST;
    end else if (cfg_write) begin
      unique case (cfg_idx)
        REG_INSIDE_WORDS:  inside_code_words   <= pwdata;
        REG_INSIDE_LEN:    inside_code_length  <= pwdata[LEN_REG_W-1:0];
        REG_OUTSIDE_WORDS: outside_code_words  <= pwdata;
        REG_OUTSIDE_LEN:   outside_code_length <= pwdata[LEN_REG_W-1:0];
        REG_VALID_MS:      signal_valid_ms     <= pwdata[AGE_W-1:0];
        REG_MISSING_OUT:   missing_is_out      <= pwdata[0];
        REG_FILTER_MS:     in_filter_ms        <= pwdata[HELD_W-1:0];
        default: ;  // unmapped address: drop the write
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_INSIDE_WORDS:  prdata = inside_code_words;
      REG_INSIDE_LEN:    prdata = DATA_W'(inside_code_length);
      REG_OUTSIDE_WORDS: prdata = outside_code_words;
      REG_OUTSIDE_LEN:   prdata = DATA_W'(outside_code_length);
      REG_VALID_MS:      prdata = DATA_W'(signal_valid_ms);
      REG_MISSING_OUT:   prdata = DATA_W'(missing_is_out);
      REG_FILTER_MS:     prdata = DATA_W'(in_filter_ms);
      default:           prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Input register and flow control
  // --------------------------------------------------------------------------
  logic     s1_valid;
  bwcd_in_t s1;
  logic     advance;

  // Advance the held request into the result register when that is free.
  assign advance    = s1_valid && (!result_valid || result_ready);
  assign item_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_ready) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      s1 <= item;
    end
  end

  // --------------------------------------------------------------------------
  // Detector state
  // --------------------------------------------------------------------------
  logic [31:0]       last_edge_time;
  logic [PROG_W-1:0] inside_progress;
  logic [PROG_W-1:0] outside_progress;
  logic              inside_flag;
  logic [AGE_W-1:0]  signal_age_ms;
  logic [HELD_W-1:0] in_held_ms;
  logic              previous_out_of_bounds;
  logic [7:0]        latest_units;

  logic [31:0]       last_edge_time_next;
  logic [PROG_W-1:0] inside_progress_next;
  logic [PROG_W-1:0] outside_progress_next;
  logic              inside_flag_next;
  logic [AGE_W-1:0]  signal_age_ms_next;
  logic [HELD_W-1:0] in_held_ms_next;
  logic [7:0]        latest_units_next;
  bwcd_out_t         result_next;

  // Pulse interval, rounded to units and saturated.
  logic [31:0]        delta;
  logic [32:0]        rounded;
  logic               saturate;
  logic [SAT_W-1:0]   div_in;
  logic [PROD_W-1:0]  product;
  logic [7:0]         units;

  assign delta    = s1.time_us - last_edge_time;
  assign rounded  = {1'b0, delta} + 33'(HALF_UNIT);
  assign saturate = rounded >= 33'(SAT_LIMIT);
  assign div_in   = rounded[SAT_W-1:0];
  assign product  = PROD_W'(div_in) * PROD_W'(RECIP);
  assign units    = saturate ? 8'hFF : 8'(product >> RSHIFT);

  // Effective code lengths: zero counts as one, clamp to CODE_MAX.
  logic [LEN_W-1:0] ilen;
  logic [LEN_W-1:0] olen;

  always_comb begin
    if (inside_code_length == '0) begin
      ilen = LEN_W'(1);
    end else if (4'(inside_code_length) > 4'(CODE_MAX)) begin
      ilen = CODE_MAX_L;
    end else begin
      ilen = LEN_W'(inside_code_length);
    end
    if (outside_code_length == '0) begin
      olen = LEN_W'(1);
    end else if (4'(outside_code_length) > 4'(CODE_MAX)) begin
      olen = CODE_MAX_L;
    end else begin
      olen = LEN_W'(outside_code_length);
    end
  end

  // Code matching: inside first, then outside with whatever inside left.
  logic [LEN_W-1:0] ip;
  logic [LEN_W-1:0] op;
  logic             is_tick;
  logic             missing;
  logic             hold_cond;
  logic             oob;

  always_comb begin
    is_tick             = (s1.action == ACT_TICK);
    last_edge_time_next = last_edge_time;
    latest_units_next   = latest_units;
    inside_flag_next    = inside_flag;
    signal_age_ms_next  = signal_age_ms;
    ip                  = LEN_W'(inside_progress);
    op                  = LEN_W'(outside_progress);

    if (is_tick) begin
      if (signal_age_ms != AGE_MAX) begin
        signal_age_ms_next = signal_age_ms + AGE_W'(1);
      end
    end else begin
      last_edge_time_next = s1.time_us;
      latest_units_next   = units;

      // Drop progress left stale by a shorter code length.
      if (ip >= ilen) begin
        ip = '0;
      end
      if (near_match(units, code_elem(inside_code_words, 3'(ip)))) begin
        ip = ip + LEN_W'(1);
        if (ip >= ilen) begin
          signal_age_ms_next = '0;
          inside_flag_next   = 1'b1;
          ip                 = '0;
          op                 = '0;
        end
      end else begin
        ip = '0;
      end

      if (op >= olen) begin
        op = '0;
      end
      if (near_match(units, code_elem(outside_code_words, 3'(op)))) begin
        op = op + LEN_W'(1);
        if (op >= olen) begin
          signal_age_ms_next = '0;
          inside_flag_next   = 1'b0;
          ip                 = '0;
          op                 = '0;
        end
      end else begin
        op = '0;
      end
    end

    inside_progress_next  = PROG_W'(ip);
    outside_progress_next = PROG_W'(op);
  end

  // Status from the updated state.
  always_comb begin
    missing   = (signal_valid_ms != '0) && (signal_age_ms_next > signal_valid_ms);
    hold_cond = inside_flag_next && !missing;
    if (!hold_cond) begin
      in_held_ms_next = '0;
    end else if (is_tick && (in_held_ms != HELD_MAX)) begin
      in_held_ms_next = in_held_ms + HELD_W'(1);
    end else begin
      in_held_ms_next = in_held_ms;
    end
    oob = missing ? missing_is_out : !inside_flag_next;

    result_next.filtered_in    = hold_cond && (in_held_ms_next >= in_filter_ms);
    result_next.raw_out        = !inside_flag_next;
    result_next.signal_missing = missing;
    result_next.out_of_bounds  = oob;
    result_next.bounds_changed = oob != previous_out_of_bounds;
    result_next.pulse_units    = latest_units_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_edge_time         <= '0;
      inside_progress        <= '0;
      outside_progress       <= '0;
      inside_flag            <= 1'b1;
      signal_age_ms          <= '0;
      in_held_ms             <= '0;
      previous_out_of_bounds <= 1'b0;
      latest_units           <= '0;
    end else if (advance) begin
      last_edge_time         <= last_edge_time_next;
      inside_progress        <= inside_progress_next;
      outside_progress       <= outside_progress_next;
      inside_flag            <= inside_flag_next;
      signal_age_ms          <= signal_age_ms_next;
      in_held_ms             <= in_held_ms_next;
      previous_out_of_bounds <= oob;
      latest_units           <= latest_units_next;
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_hold_request: assert property (@(posedge clk) disable iff (rst)
    s1_valid && result_valid && !result_ready |=> s1_valid)
    else $error("request in input register lost under stall");

  a_flag_restarts_age: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && (inside_flag != $past(inside_flag)) |-> signal_age_ms == '0)
    else $error("inside flag changed without restarting signal age");

  a_oob_follows_raw: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.signal_missing |-> result.out_of_bounds == result.raw_out)
    else $error("out_of_bounds differs from raw_out with signal present");

  a_filtered_needs_inside: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.filtered_in |-> !result.raw_out && !result.signal_missing)
    else $error("filtered_in set while outside or signal missing");

  a_held_cleared: assert property (@(posedge clk) disable iff (rst)
    !inside_flag |-> in_held_ms == '0)
    else $error("hold timer running while outside");

endmodule
